/* sv/cssl_pkg.sv */
package cssl_pkg;

    // Field and register widths
    localparam int SPEED_W    = 16;
    localparam int LIMIT_W    = 15;
    localparam int COUPLE_W   = 31;
    localparam int WIDE_W     = 18;
    localparam int PROD_W     = 2 * LIMIT_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = COUPLE_W;
    localparam int CNT_W      = 4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LINEAR_SPEED_MAX  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ANGULAR_SPEED_MAX = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LINEAR_STEP_MAX   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ANGULAR_STEP_MAX  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COUPLED_LIMIT     = 3'd4;

    // Register values after reset
    localparam logic [LIMIT_W-1:0]  RST_SPEED_MAX     = 15'd32767;
    localparam logic [LIMIT_W-1:0]  RST_STEP_MAX      = 15'd256;
    localparam logic [COUPLE_W-1:0] RST_COUPLED_LIMIT = 31'h7FFF_FFFF;

    // Largest positive Q8.8 magnitude, used when the quotient saturates
    localparam logic [LIMIT_W-1:0]  QUOT_SAT = 15'h7FFF;

    typedef logic signed [SPEED_W-1:0] speed_t;
    typedef logic signed [WIDE_W-1:0]  wide_t;

endpackage

/* sv/coupled_speed_slew_limiter.sv */
// Coupled speed slew limiter. Each item on the slave stream carries a linear and an angular
// speed order (signed Q8.8). Each order is held within one step of the last limited value
// and then within its maximum magnitude. When the magnitude of the product of the two
// speeds exceeds the coupled limit, the angular speed is kept and the linear speed becomes
// the coupled limit over the angular magnitude (saturated, with the linear sign), slewed
// again against the old linear value; tuser on the master side flags that case. A new item
// is accepted only when idle, after the last result is in the output register. A bit-serial
// shift-add multiplier forms the product and, when the limit is exceeded and the quotient
// fits, a restoring divider forms the quotient one bit a cycle. Back-pressure on the master
// side holds the result until the output is free. The user must write registers through
// the configuration port only while the block is idle; the block has no guard for it.
module coupled_speed_slew_limiter
(
    input  logic                              clk,
    input  logic                              rst_n,
    // Configuration write port
    input  logic                              cfg_we,
    input  logic [cssl_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [cssl_pkg::CFG_DATA_W-1:0]   cfg_data,
    // Slave stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [31:0]                       s_tdata,   // linear_order, angular_order
    // Master stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [31:0]                       m_tdata,   // linear_limited, angular_limited
    output logic                              m_tuser    // coupling_hit
);

    // Sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SLEW  = 3'd1;
    localparam logic [2:0] S_LIMIT = 3'd2;
    localparam logic [2:0] S_MUL   = 3'd3;
    localparam logic [2:0] S_CMP   = 3'd4;
    localparam logic [2:0] S_DIV   = 3'd5;
    localparam logic [2:0] S_FIN   = 3'd6;

    localparam logic [cssl_pkg::CNT_W-1:0] LAST_STEP =
        cssl_pkg::CNT_W'(cssl_pkg::LIMIT_W - 1);

    // Clamp a widened value into [lo, hi]
    function automatic cssl_pkg::wide_t clamp_w(cssl_pkg::wide_t x, cssl_pkg::wide_t lo,
                                                cssl_pkg::wide_t hi);
        cssl_pkg::wide_t r;
        r = x;
        if (x < lo)
        begin
            r = lo;
        end
        else if (x > hi)
        begin
            r = hi;
        end
        return r;
    endfunction

    // Configuration registers
    logic [cssl_pkg::LIMIT_W-1:0]  lin_max_reg;
    logic [cssl_pkg::LIMIT_W-1:0]  ang_max_reg;
    logic [cssl_pkg::LIMIT_W-1:0]  lin_step_reg;
    logic [cssl_pkg::LIMIT_W-1:0]  ang_step_reg;
    logic [cssl_pkg::COUPLE_W-1:0] limit_reg;

    // Control state
    logic [2:0]                    state_reg, state_next;
    logic [cssl_pkg::CNT_W-1:0]    cnt_reg, cnt_next;
    logic                          m_tvalid_reg, m_tvalid_next;
    cssl_pkg::speed_t              last_lin_reg, last_lin_next;
    cssl_pkg::speed_t              last_ang_reg, last_ang_next;

    // Working registers
    cssl_pkg::speed_t              lin_req_reg, lin_req_next;
    cssl_pkg::speed_t              ang_req_reg, ang_req_next;
    cssl_pkg::wide_t               lin_lo_reg, lin_lo_next;
    cssl_pkg::wide_t               lin_hi_reg, lin_hi_next;
    cssl_pkg::wide_t               lin_reg, lin_next;
    cssl_pkg::wide_t               ang_reg, ang_next;
    logic [cssl_pkg::LIMIT_W-1:0]  mcand_reg, mcand_next;
    logic [cssl_pkg::LIMIT_W-1:0]  mplier_reg, mplier_next;
    logic [cssl_pkg::PROD_W-1:0]   prod_reg, prod_next;
    logic [cssl_pkg::LIMIT_W-1:0]  rem_reg, rem_next;
    logic [cssl_pkg::LIMIT_W-1:0]  dvd_reg, dvd_next;
    logic [cssl_pkg::LIMIT_W-1:0]  quot_reg, quot_next;
    logic                          hit_reg, hit_next;

    // Output registers
    cssl_pkg::speed_t              out_lin_reg, out_lin_next;
    cssl_pkg::speed_t              out_ang_reg, out_ang_next;
    logic                          out_hit_reg, out_hit_next;

    // Combinational helpers
    cssl_pkg::wide_t               ang_lo, ang_hi, lin_lim, ang_lim, lin_max_w, ang_max_w;
    cssl_pkg::wide_t               quot_signed, lin_final;
    logic [cssl_pkg::LIMIT_W:0]    trial, trial_sub;
    logic                          trial_ge;
    logic                          out_free;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {out_ang_reg, out_lin_reg};
    assign m_tuser  = out_hit_reg;
    assign out_free = !m_tvalid_reg || m_tready;

    // Configuration writes; indexes beyond the list are ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lin_max_reg  <= cssl_pkg::RST_SPEED_MAX;
            ang_max_reg  <= cssl_pkg::RST_SPEED_MAX;
            lin_step_reg <= cssl_pkg::RST_STEP_MAX;
            ang_step_reg <= cssl_pkg::RST_STEP_MAX;
            limit_reg    <= cssl_pkg::RST_COUPLED_LIMIT;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                cssl_pkg::REG_LINEAR_SPEED_MAX:  lin_max_reg  <= cfg_data[cssl_pkg::LIMIT_W-1:0];
                cssl_pkg::REG_ANGULAR_SPEED_MAX: ang_max_reg  <= cfg_data[cssl_pkg::LIMIT_W-1:0];
                cssl_pkg::REG_LINEAR_STEP_MAX:   lin_step_reg <= cfg_data[cssl_pkg::LIMIT_W-1:0];
                cssl_pkg::REG_ANGULAR_STEP_MAX:  ang_step_reg <= cfg_data[cssl_pkg::LIMIT_W-1:0];
                cssl_pkg::REG_COUPLED_LIMIT:     limit_reg    <= cfg_data;
                default:                         ;
            endcase
        end
    end

    // Slew bounds and magnitude limits, widened so that no sum overflows
    always_comb
    begin
        ang_lo    = cssl_pkg::wide_t'(last_ang_reg) - cssl_pkg::wide_t'({3'b000, ang_step_reg});
        ang_hi    = cssl_pkg::wide_t'(last_ang_reg) + cssl_pkg::wide_t'({3'b000, ang_step_reg});
        lin_max_w = cssl_pkg::wide_t'({3'b000, lin_max_reg});
        ang_max_w = cssl_pkg::wide_t'({3'b000, ang_max_reg});
        lin_lim   = clamp_w(lin_reg, -lin_max_w, lin_max_w);
        ang_lim   = clamp_w(ang_reg, -ang_max_w, ang_max_w);
    end

    // One restoring division step: bring in the next dividend bit, subtract if it fits
    always_comb
    begin
        trial     = {rem_reg, dvd_reg[cssl_pkg::LIMIT_W-1]};
        trial_sub = trial - {1'b0, mcand_reg};
        trial_ge  = (trial >= {1'b0, mcand_reg});
    end

    // Coupled result: signed quotient, slewed against the old linear value
    always_comb
    begin
        if (lin_reg < 0)
        begin
            quot_signed = -cssl_pkg::wide_t'({3'b000, quot_reg});
        end
        else
        begin
            quot_signed = cssl_pkg::wide_t'({3'b000, quot_reg});
        end
        if (hit_reg)
        begin
            lin_final = clamp_w(quot_signed, lin_lo_reg, lin_hi_reg);
        end
        else
        begin
            lin_final = lin_reg;
        end
    end

    // Sequencer
    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        m_tvalid_next = m_tvalid_reg;
        last_lin_next = last_lin_reg;
        last_ang_next = last_ang_reg;
        lin_req_next  = lin_req_reg;
        ang_req_next  = ang_req_reg;
        lin_lo_next   = lin_lo_reg;
        lin_hi_next   = lin_hi_reg;
        lin_next      = lin_reg;
        ang_next      = ang_reg;
        mcand_next    = mcand_reg;
        mplier_next   = mplier_reg;
        prod_next     = prod_reg;
        rem_next      = rem_reg;
        dvd_next      = dvd_reg;
        quot_next     = quot_reg;
        hit_next      = hit_reg;
        out_lin_next  = out_lin_reg;
        out_ang_next  = out_ang_reg;
        out_hit_next  = out_hit_reg;

        // The taker of a result frees the output register
        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    lin_req_next = s_tdata[15:0];
                    ang_req_next = s_tdata[31:16];
                    state_next   = S_SLEW;
                end
            end
            S_SLEW:
            begin
                lin_lo_next = cssl_pkg::wide_t'(last_lin_reg)
                              - cssl_pkg::wide_t'({3'b000, lin_step_reg});
                lin_hi_next = cssl_pkg::wide_t'(last_lin_reg)
                              + cssl_pkg::wide_t'({3'b000, lin_step_reg});
                lin_next    = clamp_w(cssl_pkg::wide_t'(lin_req_reg), lin_lo_next, lin_hi_next);
                ang_next    = clamp_w(cssl_pkg::wide_t'(ang_req_reg), ang_lo, ang_hi);
                state_next  = S_LIMIT;
            end
            S_LIMIT:
            begin
                lin_next    = lin_lim;
                ang_next    = ang_lim;
                mplier_next = (lin_lim < 0) ? cssl_pkg::LIMIT_W'(-lin_lim)
                                            : cssl_pkg::LIMIT_W'(lin_lim);
                mcand_next  = (ang_lim < 0) ? cssl_pkg::LIMIT_W'(-ang_lim)
                                            : cssl_pkg::LIMIT_W'(ang_lim);
                prod_next   = '0;
                cnt_next    = '0;
                state_next  = S_MUL;
            end
            S_MUL:
            begin
                // Shift-add, multiplier bits taken from the top down
                prod_next   = {prod_reg[cssl_pkg::PROD_W-2:0], 1'b0}
                              + (mplier_reg[cssl_pkg::LIMIT_W-1]
                                 ? cssl_pkg::PROD_W'(mcand_reg) : '0);
                mplier_next = {mplier_reg[cssl_pkg::LIMIT_W-2:0], 1'b0};
                cnt_next    = cnt_reg + 1'b1;
                if (cnt_reg == LAST_STEP)
                begin
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                hit_next  = ({1'b0, prod_reg} > limit_reg);
                rem_next  = limit_reg[cssl_pkg::COUPLE_W-2:cssl_pkg::LIMIT_W];
                dvd_next  = limit_reg[cssl_pkg::LIMIT_W-1:0];
                quot_next = '0;
                cnt_next  = '0;
                if (({1'b0, prod_reg} > limit_reg)
                    && (limit_reg[cssl_pkg::COUPLE_W-1:cssl_pkg::LIMIT_W]
                        < {1'b0, mcand_reg}))
                begin
                    // High part of the limit below the divisor: quotient fits 15 bits
                    state_next = S_DIV;
                end
                else
                begin
                    quot_next  = cssl_pkg::QUOT_SAT;
                    state_next = S_FIN;
                end
            end
            S_DIV:
            begin
                rem_next  = trial_ge ? trial_sub[cssl_pkg::LIMIT_W-1:0]
                                     : trial[cssl_pkg::LIMIT_W-1:0];
                quot_next = {quot_reg[cssl_pkg::LIMIT_W-2:0], trial_ge};
                dvd_next  = {dvd_reg[cssl_pkg::LIMIT_W-2:0], 1'b0};
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == LAST_STEP)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    out_lin_next  = lin_final[cssl_pkg::SPEED_W-1:0];
                    out_ang_next  = ang_reg[cssl_pkg::SPEED_W-1:0];
                    out_hit_next  = hit_reg;
                    m_tvalid_next = 1'b1;
                    last_lin_next = lin_final[cssl_pkg::SPEED_W-1:0];
                    last_ang_next = ang_reg[cssl_pkg::SPEED_W-1:0];
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
            last_lin_reg <= '0;
            last_ang_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            m_tvalid_reg <= m_tvalid_next;
            last_lin_reg <= last_lin_next;
            last_ang_reg <= last_ang_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        lin_req_reg <= lin_req_next;
        ang_req_reg <= ang_req_next;
        lin_lo_reg  <= lin_lo_next;
        lin_hi_reg  <= lin_hi_next;
        lin_reg     <= lin_next;
        ang_reg     <= ang_next;
        mcand_reg   <= mcand_next;
        mplier_reg  <= mplier_next;
        prod_reg    <= prod_next;
        rem_reg     <= rem_next;
        dvd_reg     <= dvd_next;
        quot_reg    <= quot_next;
        hit_reg     <= hit_next;
        out_lin_reg <= out_lin_next;
        out_ang_reg <= out_ang_next;
        out_hit_reg <= out_hit_next;
    end

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps

module testbench;

    localparam int GAP_MAX          = 15;
    localparam int SETTLE_CYCLES    = 40;
    localparam int RANDOM_PHASES    = 10;
    localparam int ORDERS_PER_PHASE = 185;
    localparam int REPORT_MAX       = 10;

    // Indexes past the end of the register list; writes to them must be ignored.
    localparam logic [cssl_pkg::CFG_IDX_W-1:0] REG_BEYOND_LIST = 3'd5;
    localparam logic [cssl_pkg::CFG_IDX_W-1:0] REG_LAST_CODE   = 3'd7;

    typedef struct {
        cssl_pkg::speed_t linear;
        cssl_pkg::speed_t angular;
        logic             hit;
    } limited_pair_t;

    typedef enum logic {ROW_WRITE, ROW_ORDER} row_kind_t;

    typedef struct {
        row_kind_t                        kind;
        logic [cssl_pkg::CFG_IDX_W-1:0]   reg_idx;
        logic [cssl_pkg::CFG_DATA_W-1:0]  value;
        cssl_pkg::speed_t                 linear;
        cssl_pkg::speed_t                 angular;
        bit                               typed;
        limited_pair_t                    want;
    } stim_row_t;

    logic                             clk = 1'b0;
    logic                             rst_n;
    logic                             cfg_we;
    logic [cssl_pkg::CFG_IDX_W-1:0]   cfg_index;
    logic [cssl_pkg::CFG_DATA_W-1:0]  cfg_data;
    logic                             s_tvalid;
    logic                             s_tready;
    logic [31:0]                      s_tdata;
    logic                             m_tvalid;
    logic                             m_tready;
    logic [31:0]                      m_tdata;
    logic                             m_tuser;

    // Local copy of the register file and of the held speed pair.
    logic [cssl_pkg::LIMIT_W-1:0]     lin_max_cfg;
    logic [cssl_pkg::LIMIT_W-1:0]     ang_max_cfg;
    logic [cssl_pkg::LIMIT_W-1:0]     lin_step_cfg;
    logic [cssl_pkg::LIMIT_W-1:0]     ang_step_cfg;
    logic [cssl_pkg::COUPLE_W-1:0]    couple_cfg;
    cssl_pkg::speed_t                 held_linear;
    cssl_pkg::speed_t                 held_angular;

    limited_pair_t          expected_limits[$];
    stim_row_t              directed_rows[$];

    bit                     src_quiet;
    bit                     sink_quiet;
    int                     orders_sent;
    int                     results_checked;
    int                     coupled_seen;
    int                     settings_used;
    int                     faults;

    coupled_speed_slew_limiter dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),   // linear_order, angular_order
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),   // linear_limited, angular_limited
        .m_tuser   (m_tuser)    // coupling_hit
    );

    always #2 clk = ~clk;

    function automatic longint clamp_to(longint x, longint lo, longint hi);
        if (x < lo)
            return lo;
        if (x > hi)
            return hi;
        return x;
    endfunction

    // Slew and magnitude limits on both speeds, then the coupled product limit,
    // which gives the angular speed priority. Updates the held pair.
    function automatic limited_pair_t limit_speeds(cssl_pkg::speed_t lin_req,
                                                   cssl_pkg::speed_t ang_req);
        longint        lin_lo;
        longint        lin_hi;
        longint        lin;
        longint        ang;
        longint        prod;
        longint        ang_mag;
        longint        quot;
        limited_pair_t res;
        lin_lo = longint'(held_linear) - longint'(lin_step_cfg);
        lin_hi = longint'(held_linear) + longint'(lin_step_cfg);
        lin = clamp_to(longint'(lin_req), lin_lo, lin_hi);
        lin = clamp_to(lin, -longint'(lin_max_cfg), longint'(lin_max_cfg));
        ang = clamp_to(longint'(ang_req), longint'(held_angular) - longint'(ang_step_cfg),
                       longint'(held_angular) + longint'(ang_step_cfg));
        ang = clamp_to(ang, -longint'(ang_max_cfg), longint'(ang_max_cfg));
        prod = lin * ang;
        if (prod < 0)
            prod = -prod;
        res.hit = 1'b0;
        if (prod > longint'(couple_cfg))
        begin
            // A nonzero product means the angular magnitude is nonzero here.
            res.hit = 1'b1;
            ang_mag = (ang < 0) ? -ang : ang;
            quot = longint'(couple_cfg) / ang_mag;
            if (quot > longint'(cssl_pkg::QUOT_SAT))
                quot = longint'(cssl_pkg::QUOT_SAT);
            if (lin < 0)
                quot = -quot;
            lin = clamp_to(quot, lin_lo, lin_hi);
        end
        held_linear  = cssl_pkg::speed_t'(lin);
        held_angular = cssl_pkg::speed_t'(ang);
        res.linear  = held_linear;
        res.angular = held_angular;
        return res;
    endfunction

    // Mirror a register write; high bits beyond a register are dropped.
    function automatic void note_reg(logic [cssl_pkg::CFG_IDX_W-1:0] idx,
                                     logic [cssl_pkg::CFG_DATA_W-1:0] value);
        case (idx)
            cssl_pkg::REG_LINEAR_SPEED_MAX:  lin_max_cfg  = value[cssl_pkg::LIMIT_W-1:0];
            cssl_pkg::REG_ANGULAR_SPEED_MAX: ang_max_cfg  = value[cssl_pkg::LIMIT_W-1:0];
            cssl_pkg::REG_LINEAR_STEP_MAX:   lin_step_cfg = value[cssl_pkg::LIMIT_W-1:0];
            cssl_pkg::REG_ANGULAR_STEP_MAX:  ang_step_cfg = value[cssl_pkg::LIMIT_W-1:0];
            cssl_pkg::REG_COUPLED_LIMIT:     couple_cfg   = value[cssl_pkg::COUPLE_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic void add_write(logic [cssl_pkg::CFG_IDX_W-1:0] idx,
                                      logic [cssl_pkg::CFG_DATA_W-1:0] value);
        stim_row_t row;
        row.kind    = ROW_WRITE;
        row.reg_idx = idx;
        row.value   = value;
        row.linear  = '0;
        row.angular = '0;
        row.typed   = 1'b0;
        row.want    = '{linear: '0, angular: '0, hit: 1'b0};
        directed_rows.push_back(row);
    endfunction

    function automatic void add_order(cssl_pkg::speed_t lin, cssl_pkg::speed_t ang, bit typed,
                                      cssl_pkg::speed_t want_lin, cssl_pkg::speed_t want_ang,
                                      logic want_hit);
        stim_row_t row;
        row.kind    = ROW_ORDER;
        row.reg_idx = '0;
        row.value   = '0;
        row.linear  = lin;
        row.angular = ang;
        row.typed   = typed;
        row.want    = '{linear: want_lin, angular: want_ang, hit: want_hit};
        directed_rows.push_back(row);
    endfunction

    // Register value: zero, full scale, a small step, or anything, with junk above bit 14.
    function automatic logic [cssl_pkg::CFG_DATA_W-1:0] draw_limit15();
        logic [cssl_pkg::CFG_DATA_W-1:0] v;
        case ($urandom_range(0, 5))
            0:       v = '0;
            1:       v = 31'd32767;
            2:       v = 31'($urandom_range(1, 64));
            default: v = 31'($urandom_range(0, 32767));
        endcase
        if ($urandom_range(0, 3) == 0)
            v = v | (31'($urandom()) & 31'h7FFF_8000);
        return v;
    endfunction

    function automatic logic [cssl_pkg::CFG_DATA_W-1:0] draw_coupled();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return 31'h7FFF_FFFF;
            2:       return 31'($urandom_range(0, 1 << 20));
            default: return 31'($urandom_range(0, 1 << 30));
        endcase
    endfunction

    // Speed order: mostly close to the held speed so the limits matter, some anywhere.
    function automatic cssl_pkg::speed_t draw_order(cssl_pkg::speed_t held,
                                                    logic [cssl_pkg::LIMIT_W-1:0] step);
        logic [31:0] raw;
        longint      span;
        longint      v;
        case ($urandom_range(0, 9))
            0, 1, 2:
            begin
                raw = $urandom();
                v = longint'(cssl_pkg::speed_t'(raw[15:0]));
            end
            7:
            begin
                case ($urandom_range(0, 5))
                    0:       v = 32767;
                    1:       v = -32768;
                    2:       v = -32767;
                    3:       v = 1;
                    4:       v = -1;
                    default: v = 0;
                endcase
            end
            8:
                v = -longint'(held);
            default:
            begin
                span = longint'(step) + 64;
                v = longint'(held) + longint'($urandom_range(0, int'(2 * span))) - span;
            end
        endcase
        return cssl_pkg::speed_t'(clamp_to(v, -32768, 32767));
    endfunction

    // Offer one item on the slave stream and record its expected result on acceptance.
    task automatic send_order(input cssl_pkg::speed_t lin, input cssl_pkg::speed_t ang,
                              input bit typed, input limited_pair_t typed_pair);
        int            gap;
        limited_pair_t predicted;
        gap = src_quiet ? 0 : $urandom_range(0, GAP_MAX);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {ang, lin};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predicted = limit_speeds(lin, ang);
        if (typed)
            expected_limits.push_back(typed_pair);
        else
            expected_limits.push_back(predicted);
        orders_sent++;
        @(negedge clk);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (expected_limits.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [cssl_pkg::CFG_IDX_W-1:0] idx,
                             input logic [cssl_pkg::CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        note_reg(idx, value);
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // Register setting for one random phase; the first two are the extremes.
    task automatic program_phase(input int phase);
        wait_idle();
        settings_used++;
        case (phase)
            0:
            begin
                write_reg(cssl_pkg::REG_LINEAR_SPEED_MAX, 31'd32767);
                write_reg(cssl_pkg::REG_ANGULAR_SPEED_MAX, 31'd32767);
                write_reg(cssl_pkg::REG_LINEAR_STEP_MAX, 31'd32767);
                write_reg(cssl_pkg::REG_ANGULAR_STEP_MAX, 31'd32767);
                write_reg(cssl_pkg::REG_COUPLED_LIMIT, 31'h7FFF_FFFF);
            end
            1:
            begin
                write_reg(cssl_pkg::REG_LINEAR_SPEED_MAX, 31'd32767);
                write_reg(cssl_pkg::REG_ANGULAR_SPEED_MAX, 31'd32767);
                write_reg(cssl_pkg::REG_LINEAR_STEP_MAX, 31'd1);
                write_reg(cssl_pkg::REG_ANGULAR_STEP_MAX, 31'd1);
                write_reg(cssl_pkg::REG_COUPLED_LIMIT, '0);
            end
            default:
            begin
                write_reg(cssl_pkg::REG_LINEAR_SPEED_MAX, draw_limit15());
                write_reg(cssl_pkg::REG_ANGULAR_SPEED_MAX, draw_limit15());
                write_reg(cssl_pkg::REG_LINEAR_STEP_MAX, draw_limit15());
                write_reg(cssl_pkg::REG_ANGULAR_STEP_MAX, draw_limit15());
                write_reg(cssl_pkg::REG_COUPLED_LIMIT, draw_coupled());
                write_reg(REG_BEYOND_LIST + 3'($urandom_range(0, 2)), 31'($urandom()));
            end
        endcase
    endtask

    // Receiver: stalls a random number of cycles before each result.
    initial
    begin : sink_drive
        int stall;
        int taken;
        taken = 0;
        m_tready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (taken % 48 == 0)
                sink_quiet = ($urandom_range(0, 3) == 0);
            stall = sink_quiet ? 0 : $urandom_range(0, GAP_MAX);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
            taken++;
            @(negedge clk);
        end
    end

    // Compare each accepted result with the oldest expectation.
    always @(posedge clk)
    begin : result_check
        limited_pair_t    want;
        cssl_pkg::speed_t got_lin;
        cssl_pkg::speed_t got_ang;
        if (rst_n && m_tvalid && m_tready)
        begin
            got_lin = m_tdata[15:0];
            got_ang = m_tdata[31:16];
            if (expected_limits.size() == 0)
            begin
                faults++;
                if (faults <= REPORT_MAX)
                    $display("unexpected result: linear %0d angular %0d hit %0b",
                             got_lin, got_ang, m_tuser);
            end
            else
            begin
                want = expected_limits.pop_front();
                results_checked++;
                if (m_tuser)
                    coupled_seen++;
                if (got_lin !== want.linear || got_ang !== want.angular || m_tuser !== want.hit)
                begin
                    faults++;
                    if (faults <= REPORT_MAX)
                        $display("mismatch on result %0d: expected %0d %0d %0b, got %0d %0d %0b",
                                 results_checked, want.linear, want.angular, want.hit,
                                 got_lin, got_ang, m_tuser);
                end
            end
        end
    end

    initial
    begin : stimulus
        limited_pair_t    blank;
        cssl_pkg::speed_t lin;
        cssl_pkg::speed_t ang;
        int               phase;
        int               n;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        src_quiet = 1'b0;
        blank     = '{linear: '0, angular: '0, hit: 1'b0};
        lin_max_cfg  = cssl_pkg::RST_SPEED_MAX;
        ang_max_cfg  = cssl_pkg::RST_SPEED_MAX;
        lin_step_cfg = cssl_pkg::RST_STEP_MAX;
        ang_step_cfg = cssl_pkg::RST_STEP_MAX;
        couple_cfg   = cssl_pkg::RST_COUPLED_LIMIT;
        held_linear  = '0;
        held_angular = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part: extremes from reset, full-scale steps, small and zero
        // coupled limits, zero maxima, writes beyond the list, and a frozen angular step.
        add_order(16'sd32767, -16'sd32768, 1'b1, 16'sd256, -16'sd256, 1'b0);
        add_order(-16'sd32768, 16'sd32767, 1'b1, 16'sd0, 16'sd0, 1'b0);
        add_order(16'sd21845, -16'sd21846, 1'b1, 16'sd256, -16'sd256, 1'b0);
        add_order(16'sd0, 16'sd0, 1'b1, 16'sd0, 16'sd0, 1'b0);
        add_write(cssl_pkg::REG_LINEAR_STEP_MAX, 31'd32767);
        add_write(cssl_pkg::REG_ANGULAR_STEP_MAX, 31'd32767);
        add_order(16'sd32767, 16'sd32767, 1'b1, 16'sd32767, 16'sd32767, 1'b0);
        add_order(-16'sd32768, -16'sd32768, 1'b1, 16'sd0, 16'sd0, 1'b0);
        add_order(-16'sd32768, -16'sd32768, 1'b1, -16'sd32767, -16'sd32767, 1'b0);
        add_write(cssl_pkg::REG_COUPLED_LIMIT, 31'h0001_0000);
        add_order(16'sd512, 16'sd768, 1'b0, '0, '0, 1'b0);
        add_order(16'sd512, 16'sd768, 1'b0, '0, '0, 1'b0);
        add_order(-16'sd512, 16'sd768, 1'b0, '0, '0, 1'b0);
        add_write(cssl_pkg::REG_LINEAR_STEP_MAX, 31'd16);
        add_write(cssl_pkg::REG_COUPLED_LIMIT, '0);
        add_order(16'sd300, -16'sd256, 1'b0, '0, '0, 1'b0);
        add_order(16'sd300, -16'sd256, 1'b0, '0, '0, 1'b0);
        add_write(cssl_pkg::REG_LINEAR_SPEED_MAX, '0);
        add_write(cssl_pkg::REG_ANGULAR_SPEED_MAX, '0);
        add_order(16'sd1000, -16'sd1000, 1'b1, 16'sd0, 16'sd0, 1'b0);
        add_order(-16'sd1, 16'sd1, 1'b1, 16'sd0, 16'sd0, 1'b0);
        add_write(REG_BEYOND_LIST, 31'h7FFF_FFFF);
        add_write(REG_LAST_CODE, 31'h1234_5678);
        add_write(cssl_pkg::REG_LINEAR_SPEED_MAX, 31'h0001_2345);
        add_write(cssl_pkg::REG_ANGULAR_SPEED_MAX, 31'h7FFF_FFFF);
        add_write(cssl_pkg::REG_ANGULAR_STEP_MAX, '0);
        add_write(cssl_pkg::REG_COUPLED_LIMIT, 31'h0400_0000);
        add_order(16'sd32767, 16'sd32767, 1'b0, '0, '0, 1'b0);
        add_order(-16'sd32768, -16'sd32768, 1'b0, '0, '0, 1'b0);
        add_write(cssl_pkg::REG_LINEAR_STEP_MAX, 31'd256);
        add_write(cssl_pkg::REG_ANGULAR_STEP_MAX, 31'd256);
        add_write(cssl_pkg::REG_COUPLED_LIMIT, 31'h7FFF_FFFF);
        add_order(16'sd32767, 16'sd32767, 1'b0, '0, '0, 1'b0);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_WRITE)
            begin
                wait_idle();
                write_reg(directed_rows[i].reg_idx, directed_rows[i].value);
            end
            else
            begin
                send_order(directed_rows[i].linear, directed_rows[i].angular,
                           directed_rows[i].typed, directed_rows[i].want);
            end
        end

        // Random part: one register setting per phase, orders mostly near the held speeds.
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            program_phase(phase);
            for (n = 0; n < ORDERS_PER_PHASE; n++)
            begin
                if (n % 64 == 0)
                    src_quiet = ($urandom_range(0, 3) == 0);
                lin = draw_order(held_linear, lin_step_cfg);
                ang = draw_order(held_angular, ang_step_cfg);
                send_order(lin, ang, 1'b0, blank);
            end
        end

        // Drain the remaining results and let the block settle.
        s_tvalid <= 1'b0;
        while (expected_limits.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("%0d speed orders over %0d random register settings plus the directed table",
                 orders_sent, settings_used);
        $display("%0d results checked, %0d with the coupled limit active, %0d faults",
                 results_checked, coupled_seen, faults);
        if (faults == 0 && expected_limits.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Guard against a hung handshake.
    initial
    begin : watchdog
        #2_000_000;
        $display("status: fail");
        $finish;
    end

endmodule

/* files.f */
sv/cssl_pkg.sv
sv/coupled_speed_slew_limiter.sv
bench/testbench.sv
